>>> rtl/fpsqrt_pkg.sv
// Shared constants and the stage record for the fixed-point square root.
`default_nettype none

package fpsqrt_pkg;

    localparam int IN_WIDTH  = 32;
    localparam int FRAC_BITS = 16;
    localparam int ROOT_BITS = 24;

    localparam int SCALED_W = IN_WIDTH + FRAC_BITS;
    localparam int PAIRS    = SCALED_W / 2;
    localparam int RAD_W    = 2 * PAIRS;
    localparam int REM_W    = PAIRS + 2;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [PAIRS-1:0]  root;
        logic [RAD_W-1:0]  rad;
        logic              neg;
    } t_stage;

endpackage

`default_nettype wire

>>> rtl/fpsqrt_cell.sv
// One root-digit cell: brings down a bit pair, trial-subtracts, registers the result.
`default_nettype none

module fpsqrt_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_valid,
    input  wire fpsqrt_pkg::t_stage i_d,
    output logic                    o_valid,
    output fpsqrt_pkg::t_stage      o_d
);
    import fpsqrt_pkg::*;

    logic             r_valid;
    t_stage           r_d;
    t_stage           n_d;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             take;

    always_comb begin
        rem_sh = {i_d.rem, i_d.rad[RAD_W-1 -: 2]};
        trial  = (REM_W+2)'({i_d.root, 2'b01});
        take   = (rem_sh >= trial);
        n_d.rem  = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        n_d.root = {i_d.root[PAIRS-2:0], take};
        n_d.rad  = {i_d.rad[RAD_W-3:0], 2'b00};
        n_d.neg  = i_d.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

`default_nettype wire

>>> rtl/fixed_point_square_root_top.sv
// Top level of the Q16.16 fixed-point square root: a row of root-digit cells.
//
// Input channel: i_in_valid / o_in_stall carry one signed Q16.16 radicand per word.
// Output channel: o_out_valid / i_out_stall carry the floored unsigned Q8.16 root
// and a negative-input flag; a negative radicand gives root zero and the flag set.
// Each word passes through 24 cells, one per root bit, each of which registers it, so
// a word is offered at the output once it leaves the last cell, and it is taken when
// the output is not stalled. While the output is not stalled a new word may enter every
// cycle, giving one result per cycle and up to 24 words in flight.
// While the output word is stalled, the whole row holds and o_in_stall is high;
// it drops again in the cycle the output word is taken.
// Synchronous active-low reset empties the row; no word is offered after reset
// until one has gone through all the cells.
`default_nettype none

module fixed_point_square_root_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [fpsqrt_pkg::IN_WIDTH-1:0] i_radicand,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [fpsqrt_pkg::ROOT_BITS-1:0]         o_root,
    output logic                                     o_negative_error
);
    import fpsqrt_pkg::*;

    logic                adv;
    logic                neg_in;
    logic [SCALED_W-1:0] scaled;
    logic                w_v [PAIRS+1];
    t_stage              w_d [PAIRS+1];

    assign adv        = !(w_v[PAIRS] && i_out_stall);
    assign o_in_stall = !adv;

    assign neg_in = i_radicand[IN_WIDTH-1];
    assign scaled = neg_in ? '0 : (SCALED_W'($unsigned(i_radicand)) << FRAC_BITS);

    assign w_v[0]      = i_in_valid;
    assign w_d[0].rem  = '0;
    assign w_d[0].root = '0;
    assign w_d[0].rad  = RAD_W'(scaled);
    assign w_d[0].neg  = neg_in;

    for (genvar g = 0; g < PAIRS; g++) begin : g_cell
        fpsqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (w_v[g]),
            .i_d     (w_d[g]),
            .o_valid (w_v[g+1]),
            .o_d     (w_d[g+1])
        );
    end

    assign o_out_valid      = w_v[PAIRS];
    assign o_negative_error = w_d[PAIRS].neg;
    assign o_root           = w_d[PAIRS].neg ? '0 : ROOT_BITS'(w_d[PAIRS].root);

`ifndef SYNTHESIS
    a_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_negative_error |-> o_root == '0)
        else $error("negative input gave a nonzero root");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_negative_error |->
            (REM_W+1)'(w_d[PAIRS].rem) <= (REM_W+1)'({w_d[PAIRS].root, 1'b0}))
        else $error("final remainder exceeds twice the root");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled output word");
`endif

endmodule

`default_nettype wire
